// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property under clock and active-low reset.
`define RCTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed: lbl");

// A signal raised while cond holds is still raised in the next cycle.
`define RCTS_ASSERT_HOLD(lbl, clk, rstn, sig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (sig && cond) |=> sig) \
    else $error("assertion failed: lbl");

`endif

// ----- hdl/rcts_pkg.sv -----
package rcts_pkg;

  localparam int unsigned DefScreenHeight = 1024;

  localparam logic [19:0] LINE_MAX = 20'hFFFFF;
  localparam logic [25:0] TEXQ_MAX = 26'h3FFFFFF;
  localparam logic [10:0] COL_MAX  = 11'd1023;

  // Texture row dividend: tex_height << 16.
  localparam int unsigned TexNumW = 27;

  typedef struct packed {
    logic [9:0]  col;
    logic [10:0] th;
  } side1_t;

  typedef struct packed {
    logic [19:0] line;
    logic [9:0]  start;
    logic [9:0]  stop;
    logic [9:0]  col;
    logic [19:0] a;
    logic        apos;
  } side2_t;

endpackage

// ----- hdl/raycast_column_texture_setup.sv -----
// Textured wall column setup for a grid raycaster. Each beat carries one
// screen column's DDA result; the block returns the projected line height,
// the clamped first and last wall rows, the texture column (mirrored by wall
// side and ray sign) and the Q10.16 texture row step and start position.
// A new beat is taken every cycle as long as the output side keeps up; the
// whole pipeline advances together and holds on an output stall. A beat passes
// the front stages, the bit-per-stage restoring line height divider, the mid
// stage, the texture row step divider of the same kind, and the tail stages.
module raycast_column_texture_setup #(
  parameter int unsigned SCREEN_HEIGHT = rcts_pkg::DefScreenHeight
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         side_i,
  input  logic [31:0]        side_dist_x_i,
  input  logic [31:0]        delta_dist_x_i,
  input  logic [31:0]        side_dist_y_i,
  input  logic [31:0]        delta_dist_y_i,
  input  logic [23:0]        pos_x_i,
  input  logic [23:0]        pos_y_i,
  input  logic signed [17:0] ray_dir_x_i,
  input  logic signed [17:0] ray_dir_y_i,
  input  logic [10:0]        tex_width_i,
  input  logic [10:0]        tex_height_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [19:0]        line_height_o,
  output logic [9:0]         span_start_o,
  output logic [9:0]         span_end_o,
  output logic [9:0]         tex_column_o,
  output logic [25:0]        tex_row_start_o,
  output logic [25:0]        tex_row_step_o
);
  import rcts_pkg::*;

  localparam int unsigned LineNumW = $clog2(SCREEN_HEIGHT) + 17;
  localparam int unsigned S1W      = $bits(side1_t);
  localparam int unsigned S2W      = $bits(side2_t);

  logic                adv;
  logic                f_vld, d1_vld, m_vld, d2_vld;
  logic [31:0]         perp_dist;
  side1_t              f_side, d1_side;
  logic [S1W-1:0]      d1_side_raw;
  logic [LineNumW-1:0] line_quo;
  logic [19:0]         line;
  logic [10:0]         th;
  side2_t              m_side, d2_side;
  logic [S2W-1:0]      d2_side_raw;
  logic [TexNumW-1:0]  step_quo;

  // Advance every stage together; hold everything while the result waits.
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  rcts_front u_front (
    .clk_i, .rst_ni,
    .en_i          (adv),
    .vld_i         (in_valid_i),
    .side_i, .side_dist_x_i, .delta_dist_x_i, .side_dist_y_i, .delta_dist_y_i,
    .pos_x_i, .pos_y_i, .ray_dir_x_i, .ray_dir_y_i, .tex_width_i, .tex_height_i,
    .vld_o         (f_vld),
    .dist_o        (perp_dist),
    .side_o        (f_side)
  );

  // Line height: (SCREEN_HEIGHT << 16) / distance; zero distance saturates.
  rcts_div #(.NW(LineNumW), .DW(32), .SW(S1W)) u_div_line (
    .clk_i, .rst_ni,
    .en_i   (adv),
    .vld_i  (f_vld),
    .num_i  (LineNumW'(SCREEN_HEIGHT) << 16),
    .den_i  (perp_dist),
    .side_i (f_side),
    .vld_o  (d1_vld),
    .quo_o  (line_quo),
    .side_o (d1_side_raw)
  );
  assign d1_side = side1_t'(d1_side_raw);

  rcts_mid #(.SCREEN_HEIGHT(SCREEN_HEIGHT), .NW(LineNumW)) u_mid (
    .clk_i, .rst_ni,
    .en_i   (adv),
    .vld_i  (d1_vld),
    .quo_i  (line_quo),
    .side_i (d1_side),
    .vld_o  (m_vld),
    .line_o (line),
    .th_o   (th),
    .side_o (m_side)
  );

  // Texture row step: (tex_height << 16) / line_height.
  rcts_div #(.NW(TexNumW), .DW(20), .SW(S2W)) u_div_step (
    .clk_i, .rst_ni,
    .en_i   (adv),
    .vld_i  (m_vld),
    .num_i  ({th, 16'h0}),
    .den_i  (line),
    .side_i (m_side),
    .vld_o  (d2_vld),
    .quo_o  (step_quo),
    .side_o (d2_side_raw)
  );
  assign d2_side = side2_t'(d2_side_raw);

  rcts_tail u_tail (
    .clk_i, .rst_ni,
    .en_i   (adv),
    .vld_i  (d2_vld),
    .quo_i  (step_quo),
    .side_i (d2_side),
    .vld_o  (out_valid_o),
    .line_height_o, .span_start_o, .span_end_o, .tex_column_o,
    .tex_row_start_o, .tex_row_step_o
  );
endmodule

// ----- hdl/rcts_front.sv -----
module rcts_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [1:0]         side_i,
  input  logic [31:0]        side_dist_x_i,
  input  logic [31:0]        delta_dist_x_i,
  input  logic [31:0]        side_dist_y_i,
  input  logic [31:0]        delta_dist_y_i,
  input  logic [23:0]        pos_x_i,
  input  logic [23:0]        pos_y_i,
  input  logic signed [17:0] ray_dir_x_i,
  input  logic signed [17:0] ray_dir_y_i,
  input  logic [10:0]        tex_width_i,
  input  logic [10:0]        tex_height_i,
  output logic               vld_o,
  output logic [31:0]        dist_o,
  output rcts_pkg::side1_t   side_o
);
  import rcts_pkg::*;

  logic [2:0]         vld_q;
  logic [31:0]        dist_d, dist1_q, dist2_q, dist3_q;
  logic [15:0]        pos_d, pos_q;
  logic signed [17:0] ray_d, ray_q;
  logic               mir_d, mir1_q, mir2_q;
  logic [10:0]        tw1_q, tw2_q, th1_q, th2_q, th3_q;
  logic               xside;
  logic signed [50:0] hprod;
  logic [31:0]        frac_d, frac_q;
  logic [42:0]        cprod;
  logic [10:0]        raw, mcol;
  logic [9:0]         col_d, col_q;

  // Stage 1: perpendicular distance and side selection.
  always_comb begin
    xside  = !side_i[1];
    if (xside) begin
      dist_d = (side_dist_x_i > delta_dist_x_i) ? side_dist_x_i - delta_dist_x_i : '0;
      pos_d  = pos_y_i[15:0];
      ray_d  = ray_dir_y_i;
      mir_d  = ray_dir_x_i[17];
    end else begin
      dist_d = (side_dist_y_i > delta_dist_y_i) ? side_dist_y_i - delta_dist_y_i : '0;
      pos_d  = pos_x_i[15:0];
      ray_d  = ray_dir_x_i;
      mir_d  = !ray_dir_y_i[17] && (ray_dir_y_i != '0);
    end
  end

  // Stage 2: fractional wall hit coordinate.
  assign hprod  = $signed({1'b0, dist1_q}) * ray_q;
  assign frac_d = {pos_q, 16'h0} + hprod[31:0];

  // Stage 3: texture column, mirrored and saturated.
  assign cprod = frac_q * tw2_q;
  assign raw   = cprod[42:32];
  assign mcol  = mir2_q ? tw2_q - raw - 11'd1 : raw;
  always_comb begin
    if (tw2_q == '0) col_d = '0;
    else if (mcol > COL_MAX) col_d = COL_MAX[9:0];
    else col_d = mcol[9:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist1_q <= dist_d;
      pos_q   <= pos_d;
      ray_q   <= ray_d;
      mir1_q  <= mir_d;
      tw1_q   <= tex_width_i;
      th1_q   <= tex_height_i;
      dist2_q <= dist1_q;
      frac_q  <= frac_d;
      mir2_q  <= mir1_q;
      tw2_q   <= tw1_q;
      th2_q   <= th1_q;
      dist3_q <= dist2_q;
      col_q   <= col_d;
      th3_q   <= th2_q;
    end
  end

  assign vld_o       = vld_q[2];
  assign dist_o      = dist3_q;
  assign side_o.col  = col_q;
  assign side_o.th   = th3_q;
endmodule

// ----- hdl/rcts_div.sv -----
module rcts_div #(
  parameter int unsigned NW = 27,
  parameter int unsigned DW = 32,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);
  logic [NW-1:0] num_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [SW-1:0] side_q [NW];
  logic [NW-1:0] vld_q;

  // One quotient bit per stage, restoring form.
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] num_p, quo_p;
    logic [DW-1:0] rem_p, den_p;
    logic [SW-1:0] side_p;
    logic          vld_p;
    logic [DW:0]   t, diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign num_p  = num_i;
      assign quo_p  = '0;
      assign rem_p  = '0;
      assign den_p  = den_i;
      assign side_p = side_i;
      assign vld_p  = vld_i;
    end else begin : g_next
      assign num_p  = num_q[k-1];
      assign quo_p  = quo_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign den_p  = den_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    assign t    = {rem_p, num_p[NW-1]};
    assign ge   = t >= {1'b0, den_p};
    assign diff = t - {1'b0, den_p};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k]  <= {num_p[NW-2:0], 1'b0};
        quo_q[k]  <= {quo_p[NW-2:0], ge};
        rem_q[k]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        den_q[k]  <= den_p;
        side_q[k] <= side_p;
      end
    end
  end

  assign vld_o  = vld_q[NW-1];
  assign quo_o  = quo_q[NW-1];
  assign side_o = side_q[NW-1];
endmodule

// ----- hdl/rcts_mid.sv -----
module rcts_mid #(
  parameter int unsigned SCREEN_HEIGHT = rcts_pkg::DefScreenHeight,
  parameter int unsigned NW = $clog2(SCREEN_HEIGHT) + 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [NW-1:0]    quo_i,
  input  rcts_pkg::side1_t side_i,
  output logic             vld_o,
  output logic [19:0]      line_o,
  output logic [10:0]      th_o,
  output rcts_pkg::side2_t side_o
);
  import rcts_pkg::*;

  localparam logic [19:0] Half = 20'(SCREEN_HEIGHT / 2);
  localparam logic [19:0] Sh   = 20'(SCREEN_HEIGHT);

  logic [19:0] line, lh, start, stop, sum;
  logic [21:0] a;
  logic        vld_q;
  logic [19:0] line_q;
  logic [10:0] th_q;
  side2_t      s_d, s_q;

  always_comb begin
    line  = (quo_i > NW'(LINE_MAX)) ? LINE_MAX : quo_i[19:0];
    lh    = {1'b0, line[19:1]};
    start = (lh >= Half) ? '0 : Half - lh;
    sum   = lh + Half;
    stop  = (sum >= Sh) ? Sh - 20'd1 : sum;
    a     = {1'b0, start, 1'b0} + {2'b0, line} - {2'b0, Sh};
    s_d.line  = line;
    s_d.start = start[9:0];
    s_d.stop  = stop[9:0];
    s_d.col   = side_i.col;
    s_d.a     = a[19:0];
    s_d.apos  = !a[21] && (a != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q    <= s_d;
      line_q <= line;
      th_q   <= side_i.th;
    end
  end

  assign vld_o  = vld_q;
  assign line_o = line_q;
  assign th_o   = th_q;
  assign side_o = s_q;
endmodule

// ----- hdl/rcts_tail.sv -----
module rcts_tail (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [rcts_pkg::TexNumW-1:0] quo_i,
  input  rcts_pkg::side2_t          side_i,
  output logic                      vld_o,
  output logic [19:0]               line_height_o,
  output logic [9:0]                span_start_o,
  output logic [9:0]                span_end_o,
  output logic [9:0]                tex_column_o,
  output logic [25:0]               tex_row_start_o,
  output logic [25:0]               tex_row_step_o
);
  import rcts_pkg::*;

  logic [25:0] step_d, step_q, step_o_q, ts_d, ts_q;
  logic [45:0] prod_d, prod_q;
  side2_t      s_q, s_o_q;
  logic [1:0]  vld_q;

  // A zero line height divides to all ones and saturates here too.
  assign step_d = (quo_i > TexNumW'(TEXQ_MAX)) ? TEXQ_MAX : quo_i[25:0];
  assign prod_d = side_i.a * step_d;

  always_comb begin
    if (!s_q.apos) ts_d = '0;
    else if (prod_q[45:1] > 45'(TEXQ_MAX)) ts_d = TEXQ_MAX;
    else ts_d = prod_q[26:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q   <= step_d;
      prod_q   <= prod_d;
      s_q      <= side_i;
      step_o_q <= step_q;
      ts_q     <= ts_d;
      s_o_q    <= s_q;
    end
  end

  assign vld_o           = vld_q[1];
  assign line_height_o   = s_o_q.line;
  assign span_start_o    = s_o_q.start;
  assign span_end_o      = s_o_q.stop;
  assign tex_column_o    = s_o_q.col;
  assign tex_row_start_o = ts_q;
  assign tex_row_step_o  = step_o_q;
endmodule

// ----- hdl/rcts_checker.sv -----
`include "assert_macros.svh"

module rcts_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i
);
  // An empty output stage always takes a beat.
  `RCTS_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o)
  // A drained result frees the pipeline in the same cycle.
  `RCTS_ASSERT(a_ready_on_drain, clk_i, rst_ni, (out_valid_o && out_ready_i) |-> in_ready_o)
  // A stalled result stays offered.
  `RCTS_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, !out_ready_i)
endmodule

bind raycast_column_texture_setup rcts_checker u_rcts_checker (.*);
